FILE: hdl/ssfs_pkg.sv
// ----------------------------------------------------------------------------
// Sensor source failover selector package
// Shared types, code values and constants of the source selector.
// ----------------------------------------------------------------------------
package ssfs_pkg;

	localparam int unsigned TIME_W  = 64;
	localparam int unsigned AGE_W   = 40;
	localparam int unsigned RCNT_W  = 32;
	localparam int unsigned EPOUT_W = 32;
	localparam int unsigned IN_W    = 232;
	localparam int unsigned OUT_W   = 112;

	// Value checked against the skew limit when a time is not positive: one second.
	localparam logic [AGE_W-1:0] AGE_UNKNOWN_NS = 40'd1000000000;

	typedef enum logic [2:0] {
		REG_ENABLED      = 3'd0,
		REG_NOMINAL_INER = 3'd1,
		REG_FALLBACK_ODO = 3'd2,
		REG_LATCH_FB     = 3'd3,
		REG_MAX_INER_AGE = 3'd4,
		REG_MAX_ODO_AGE  = 3'd5,
		REG_MAX_SKEW     = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_UNCONFIGURED = 3'd0,
		ST_WAITING      = 3'd1,
		ST_NOMINAL_ODO  = 3'd2,
		ST_NOMINAL_INER = 3'd3,
		ST_FALLBACK     = 3'd4,
		ST_FAIL_CLOSED  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		RS_NONE          = 3'd0,
		RS_INER_NOT_RDY  = 3'd1,
		RS_INER_INVALID  = 3'd2,
		RS_INER_STALE    = 3'd3,
		RS_ODO_INVALID   = 3'd4,
		RS_ODO_STALE     = 3'd5
	} reason_t;

	typedef enum logic [1:0] {
		SRC_NONE     = 2'd0,
		SRC_ODOMETRY = 2'd1,
		SRC_INERTIAL = 2'd2
	} source_t;

	typedef struct packed {
		logic             enabled;
		logic             nominal_is_inertial;
		logic             fallback_to_odometry;
		logic             hold_on_fallback;
		logic [AGE_W-1:0] max_inertial_age_ns;
		logic [AGE_W-1:0] max_odometry_age_ns;
		logic [AGE_W-1:0] max_future_skew_ns;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_time_ns;
		logic [TIME_W-1:0] odometry_stamp_ns;
		logic              odometry_health_ok;
		logic [TIME_W-1:0] inertial_stamp_ns;
		logic              inertial_health_ok;
		logic              inertial_pipeline_ready;
		logic [RCNT_W-1:0] inertial_reset_count;
	} item_t;

	typedef struct packed {
		logic valid;
		logic fresh;
	} judge_t;

	typedef struct packed {
		status_t            status_code;
		reason_t            reason_code;
		logic               output_valid;
		source_t            chosen_source;
		logic [TIME_W-1:0]  chosen_stamp_ns;
		logic               fallback_engaged;
		logic               fallback_held;
		logic               nominal_seen_ready;
		logic               odometry_fresh;
		logic               inertial_fresh;
		logic [EPOUT_W-1:0] change_epoch;
	} result_t;

endpackage

FILE: hdl/ssfs_fresh.sv
// ----------------------------------------------------------------------------
// Source freshness judge
// Decides whether one source is valid and whether its age lies in the window.
// ----------------------------------------------------------------------------
module ssfs_fresh (
	input  logic [ssfs_pkg::TIME_W-1:0] now_time_ns,
	input  logic [ssfs_pkg::TIME_W-1:0] stamp_ns,
	input  logic                        health_ok,
	input  logic [ssfs_pkg::AGE_W-1:0]  max_age_ns,
	input  logic [ssfs_pkg::AGE_W-1:0]  max_skew_ns,
	output ssfs_pkg::judge_t            judge
);
	import ssfs_pkg::*;

	logic              now_pos;
	logic              stamp_pos;
	logic              now_ge;
	logic [TIME_W-2:0] age_ns;
	logic [TIME_W-2:0] lead_ns;
	logic              in_window;

	assign now_pos   = (now_time_ns != '0) && !now_time_ns[TIME_W-1];
	assign stamp_pos = (stamp_ns != '0) && !stamp_ns[TIME_W-1];
	assign now_ge    = now_time_ns[TIME_W-2:0] >= stamp_ns[TIME_W-2:0];
	assign age_ns    = now_time_ns[TIME_W-2:0] - stamp_ns[TIME_W-2:0];
	assign lead_ns   = stamp_ns[TIME_W-2:0] - now_time_ns[TIME_W-2:0];

	always_comb begin
		if (!now_pos || !stamp_pos) begin
			in_window = AGE_UNKNOWN_NS <= max_skew_ns;
		end else if (now_ge) begin
			in_window = age_ns <= (TIME_W-1)'(max_age_ns);
		end else begin
			in_window = lead_ns <= (TIME_W-1)'(max_skew_ns);
		end
	end

	assign judge.valid = health_ok && stamp_pos;
	assign judge.fresh = health_ok && stamp_pos && in_window;

endmodule

FILE: hdl/ssfs_core.sv
// ----------------------------------------------------------------------------
// Selection core
// Chooses the source, holds the latched fallback and tracks the change epoch.
// ----------------------------------------------------------------------------
module ssfs_core #(
	parameter int unsigned EPOCH_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         clear,
	input  ssfs_pkg::cfg_t               cfg,
	input  ssfs_pkg::item_t              item,
	input  ssfs_pkg::judge_t             odo_judge,
	input  ssfs_pkg::judge_t             iner_judge,
	output ssfs_pkg::result_t            result
);
	import ssfs_pkg::*;

	logic                  ever_ready_q;
	logic                  latched_q;
	reason_t               latched_reason_q;
	logic                  have_prior_q;
	logic                  prior_valid_q;
	logic                  prior_latched_q;
	source_t               prior_source_q;
	status_t               prior_status_q;
	reason_t               prior_reason_q;
	logic [RCNT_W-1:0]     prior_rcount_q;
	logic [EPOCH_BITS-1:0] epoch_q;

	logic                  ever_ready_d;
	logic                  latched_d;
	reason_t               latched_reason_d;
	logic [EPOCH_BITS-1:0] epoch_d;

	logic                  configured;
	logic                  nominal_iner;
	logic                  odo_fresh;
	logic                  iner_fresh;
	logic                  iner_avail;
	reason_t               odo_reason;
	reason_t               iner_reason;
	status_t               status;
	reason_t               reason;
	source_t               source;
	logic                  valid;
	logic                  fb_active;
	logic                  fb_held;
	logic                  seen;
	logic [TIME_W-1:0]     stamp;
	logic                  changed;

	assign configured = cfg.enabled && (cfg.max_inertial_age_ns != '0)
		&& (cfg.max_odometry_age_ns != '0);
	assign odo_fresh    = configured && odo_judge.fresh;
	assign iner_fresh   = configured && iner_judge.fresh;
	assign iner_avail   = item.inertial_pipeline_ready && iner_fresh;
	assign nominal_iner = configured && cfg.nominal_is_inertial;
	assign odo_reason   = odo_judge.valid ? RS_ODO_STALE : RS_ODO_INVALID;

	always_comb begin
		if (!item.inertial_pipeline_ready) begin
			iner_reason = RS_INER_NOT_RDY;
		end else if (!iner_judge.valid) begin
			iner_reason = RS_INER_INVALID;
		end else begin
			iner_reason = RS_INER_STALE;
		end
	end

	always_comb begin
		status           = ST_UNCONFIGURED;
		reason           = RS_NONE;
		source           = SRC_NONE;
		valid            = 1'b0;
		fb_active        = 1'b0;
		fb_held          = 1'b0;
		seen             = 1'b0;
		stamp            = '0;
		ever_ready_d     = ever_ready_q;
		latched_d        = latched_q;
		latched_reason_d = latched_reason_q;
		if (configured) begin
			if (!cfg.nominal_is_inertial) begin
				seen = odo_fresh;
				if (odo_fresh) begin
					valid  = 1'b1;
					source = SRC_ODOMETRY;
					stamp  = item.odometry_stamp_ns;
					status = ST_NOMINAL_ODO;
				end else begin
					status = ST_FAIL_CLOSED;
					reason = odo_reason;
				end
			end else if (latched_q) begin
				fb_held = 1'b1;
				seen    = ever_ready_q;
				if (odo_fresh) begin
					valid     = 1'b1;
					source    = SRC_ODOMETRY;
					stamp     = item.odometry_stamp_ns;
					fb_active = 1'b1;
					status    = ST_FALLBACK;
					reason    = latched_reason_q;
				end else begin
					status = ST_FAIL_CLOSED;
					reason = odo_reason;
				end
			end else if (iner_avail) begin
				ever_ready_d = 1'b1;
				valid        = 1'b1;
				source       = SRC_INERTIAL;
				stamp        = item.inertial_stamp_ns;
				status       = ST_NOMINAL_INER;
				seen         = 1'b1;
			end else begin
				reason = iner_reason;
				seen   = ever_ready_q;
				if (!ever_ready_q) begin
					status = ST_WAITING;
				end else if (cfg.fallback_to_odometry && odo_fresh) begin
					valid     = 1'b1;
					source    = SRC_ODOMETRY;
					stamp     = item.odometry_stamp_ns;
					fb_active = 1'b1;
					status    = ST_FALLBACK;
					if (cfg.hold_on_fallback) begin
						latched_d        = 1'b1;
						latched_reason_d = iner_reason;
						fb_held          = 1'b1;
					end
				end else begin
					status = ST_FAIL_CLOSED;
				end
			end
		end
	end

	assign changed = !have_prior_q || (valid != prior_valid_q) || (fb_held != prior_latched_q)
		|| (source != prior_source_q) || (status != prior_status_q)
		|| (reason != prior_reason_q)
		|| (nominal_iner && (item.inertial_reset_count != prior_rcount_q));
	assign epoch_d = changed ? epoch_q + EPOCH_BITS'(1) : epoch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ever_ready_q     <= 1'b0;
			latched_q        <= 1'b0;
			latched_reason_q <= RS_NONE;
			have_prior_q     <= 1'b0;
			prior_valid_q    <= 1'b0;
			prior_latched_q  <= 1'b0;
			prior_source_q   <= SRC_NONE;
			prior_status_q   <= ST_UNCONFIGURED;
			prior_reason_q   <= RS_NONE;
			prior_rcount_q   <= '0;
			epoch_q          <= '0;
		end else if (clear) begin
			ever_ready_q     <= 1'b0;
			latched_q        <= 1'b0;
			latched_reason_q <= RS_NONE;
			have_prior_q     <= 1'b0;
			prior_valid_q    <= 1'b0;
			prior_latched_q  <= 1'b0;
			prior_source_q   <= SRC_NONE;
			prior_status_q   <= ST_UNCONFIGURED;
			prior_reason_q   <= RS_NONE;
			prior_rcount_q   <= '0;
			epoch_q          <= '0;
		end else if (advance) begin
			ever_ready_q     <= ever_ready_d;
			latched_q        <= latched_d;
			latched_reason_q <= latched_reason_d;
			have_prior_q     <= 1'b1;
			prior_valid_q    <= valid;
			prior_latched_q  <= fb_held;
			prior_source_q   <= source;
			prior_status_q   <= status;
			prior_reason_q   <= reason;
			prior_rcount_q   <= item.inertial_reset_count;
			epoch_q          <= epoch_d;
		end
	end

	assign result.status_code        = status;
	assign result.reason_code        = reason;
	assign result.output_valid       = valid;
	assign result.chosen_source      = source;
	assign result.chosen_stamp_ns    = stamp;
	assign result.fallback_engaged   = fb_active;
	assign result.fallback_held      = fb_held;
	assign result.nominal_seen_ready = seen;
	assign result.odometry_fresh     = odo_fresh;
	assign result.inertial_fresh     = iner_fresh;
	assign result.change_epoch       = EPOUT_W'(epoch_d);

endmodule

FILE: hdl/sensor_source_failover_selector_unit.sv
// ----------------------------------------------------------------------------
// Sensor source failover selector
// Picks odometry or processed inertial estimates by freshness and policy.
// ----------------------------------------------------------------------------
// The input transaction is registered in item_s1 and its result in result_s2.
// Throughput: one transaction per cycle, set by the input and result registers, while m_axis_tready does not stall.
// The freshness judges and selection logic sit between the two registers.
// Reset clears all selection state and returns the configuration registers to their defaults.
module sensor_source_failover_selector_unit #(
	parameter int unsigned EPOCH_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [ssfs_pkg::AGE_W-1:0]   cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// now_time_ns[63:0], odometry_stamp_ns[127:64], odometry_health_ok[128],
	// inertial_stamp_ns[192:129], inertial_health_ok[193],
	// inertial_pipeline_ready[194], inertial_reset_count[226:195], zero pad.
	input  logic [ssfs_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// status_code[2:0], reason_code[5:3], output_valid[6], chosen_source[8:7],
	// chosen_stamp_ns[72:9], fallback_engaged[73], fallback_held[74],
	// nominal_seen_ready[75], odometry_fresh[76], inertial_fresh[77],
	// change_epoch[109:78], zero pad.
	output logic [ssfs_pkg::OUT_W-1:0]   m_axis_tdata
);
	import ssfs_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    advance;
	logic    clear;
	judge_t  odo_judge;
	judge_t  iner_judge;
	result_t result;

	assign clear = cfg_we && (cfg_index == REG_ENABLED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled              <= 1'b0;
			cfg_q.nominal_is_inertial  <= 1'b1;
			cfg_q.fallback_to_odometry <= 1'b0;
			cfg_q.hold_on_fallback     <= 1'b1;
			cfg_q.max_inertial_age_ns  <= 40'd100000000;
			cfg_q.max_odometry_age_ns  <= 40'd100000000;
			cfg_q.max_future_skew_ns   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLED:      cfg_q.enabled              <= cfg_data[0];
				REG_NOMINAL_INER: cfg_q.nominal_is_inertial  <= cfg_data[0];
				REG_FALLBACK_ODO: cfg_q.fallback_to_odometry <= cfg_data[0];
				REG_LATCH_FB:     cfg_q.hold_on_fallback     <= cfg_data[0];
				REG_MAX_INER_AGE: cfg_q.max_inertial_age_ns  <= cfg_data;
				REG_MAX_ODO_AGE:  cfg_q.max_odometry_age_ns  <= cfg_data;
				REG_MAX_SKEW:     cfg_q.max_future_skew_ns   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.now_time_ns             <= s_axis_tdata[63:0];
			item_s1.odometry_stamp_ns       <= s_axis_tdata[127:64];
			item_s1.odometry_health_ok      <= s_axis_tdata[128];
			item_s1.inertial_stamp_ns       <= s_axis_tdata[192:129];
			item_s1.inertial_health_ok      <= s_axis_tdata[193];
			item_s1.inertial_pipeline_ready <= s_axis_tdata[194];
			item_s1.inertial_reset_count    <= s_axis_tdata[226:195];
		end
	end

	ssfs_fresh u_odo_fresh (
		.now_time_ns (item_s1.now_time_ns),
		.stamp_ns    (item_s1.odometry_stamp_ns),
		.health_ok   (item_s1.odometry_health_ok),
		.max_age_ns  (cfg_q.max_odometry_age_ns),
		.max_skew_ns (cfg_q.max_future_skew_ns),
		.judge       (odo_judge)
	);

	ssfs_fresh u_iner_fresh (
		.now_time_ns (item_s1.now_time_ns),
		.stamp_ns    (item_s1.inertial_stamp_ns),
		.health_ok   (item_s1.inertial_health_ok),
		.max_age_ns  (cfg_q.max_inertial_age_ns),
		.max_skew_ns (cfg_q.max_future_skew_ns),
		.judge       (iner_judge)
	);

	ssfs_core #(
		.EPOCH_BITS (EPOCH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.clear      (clear),
		.cfg        (cfg_q),
		.item       (item_s1),
		.odo_judge  (odo_judge),
		.iner_judge (iner_judge),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00,
		result_s2.change_epoch,
		result_s2.inertial_fresh,
		result_s2.odometry_fresh,
		result_s2.nominal_seen_ready,
		result_s2.fallback_held,
		result_s2.fallback_engaged,
		result_s2.chosen_stamp_ns,
		result_s2.chosen_source,
		result_s2.output_valid,
		result_s2.reason_code,
		result_s2.status_code};

endmodule

FILE: hdl/ssfs_checker.sv
// ----------------------------------------------------------------------------
// Selector port checker
// Watches the ports of the selector for flow and result consistency.
// ----------------------------------------------------------------------------
module ssfs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [ssfs_pkg::OUT_W-1:0] m_axis_tdata
);
	import ssfs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result transaction changed.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("Result transaction did not follow its input.");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("Input stalled while the result side was empty.");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[6] == (m_axis_tdata[8:7] != SRC_NONE))
			&& ((m_axis_tdata[8:7] != SRC_NONE) || (m_axis_tdata[72:9] == '0)))
		else $error("Chosen source disagrees with output valid or stamp.");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[73] |->
			(m_axis_tdata[8:7] == SRC_ODOMETRY) && (m_axis_tdata[2:0] == ST_FALLBACK))
		else $error("Fallback shown without odometry selected.");

endmodule

bind sensor_source_failover_selector_unit ssfs_checker u_ssfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
